### rtl/core/voice_allocator_with_steal_macros.svh
// assertion helpers for the voice allocator rtl
`ifndef VOICE_ALLOCATOR_WITH_STEAL_MACROS_SVH
`define VOICE_ALLOCATOR_WITH_STEAL_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VAWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define VAWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/vaws_pkg.sv
`default_nettype none

package vaws_pkg;

  localparam int TimerW = 16;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_START = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_STEAL = 5'b00100,
    S_DONE  = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  // results of the shared timer unit
  typedef struct packed {
    logic              zero;
    logic              lt;
    logic [TimerW-1:0] dec;
  } alu_res_t;

endpackage

`default_nettype wire

### rtl/core/vaws_ram.sv
`default_nettype none

module vaws_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic             re,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/vaws_alu.sv
`default_nettype none

// one compare/decrement unit reused for every entry of a scan
module vaws_alu (
  input  wire logic [vaws_pkg::TimerW-1:0] timer,
  input  wire logic [vaws_pkg::TimerW:0]   best,
  output vaws_pkg::alu_res_t               res
);

  always_comb begin
    res.zero = (timer == '0);
    res.lt   = ({1'b0, timer} < best);
    res.dec  = timer - vaws_pkg::TimerW'(1);
  end

endmodule

`default_nettype wire

### rtl/core/voice_allocator_with_steal.sv
`default_nettype none

// Voice allocator with shortest-remaining steal. Items: kind 0 tick, 1 allocate,
// 2 start note, 3 no operation; every item returns exactly one result item.
// Start note and no operation go from acceptance straight to the done state and
// take the next input item once their result has moved into the output register.
// Tick and allocate walk the timer memory one entry per cycle through a single
// compare/decrement unit: a full walk ends in the done state, and the next input
// item is taken once the result has moved into the output register (allocate
// stops early at the first free channel, and a steal passes through a steal state).
// The timer table is a registered-read RAM; busy flags and timer valid bits are
// flops cleared by reset, so no clearing pass is needed after reset. in_ready is
// high whenever no item is in progress; a finished result waits in the output
// register without blocking the next input.
module voice_allocator_with_steal #(
  parameter int CHANNELS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_kind,
  input  wire logic [4:0] in_chan,
  input  wire logic [15:0] in_duration,
  input  wire logic       in_track_valid,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_granted_chan,
  output logic            out_stolen,
  output logic [5:0]      out_voices_in_use
);

`include "voice_allocator_with_steal_macros.svh"

  localparam int IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNTW = $clog2(CHANNELS + 1);
  localparam int TW   = vaws_pkg::TimerW;
  localparam logic [IW-1:0]   LastIdx = IW'(CHANNELS - 1);
  localparam logic [CNTW-1:0] MaxCnt  = CNTW'(CHANNELS);

  vaws_pkg::state_t state_r, state_nxt;
  vaws_pkg::kind_t  kind_r, kind_nxt, in_kind_c;

  logic [IW-1:0]   scan_idx_r, scan_idx_nxt;
  logic            iss_r, iss_nxt;
  logic            ph_vld_r, ph_vld_nxt;
  logic [IW-1:0]   ph_idx_r, ph_idx_nxt;
  logic [TW:0]     best_val_r, best_val_nxt;
  logic [IW-1:0]   best_idx_r, best_idx_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CHANNELS-1:0] busy_r, busy_nxt;
  logic [CHANNELS-1:0] tval_r, tval_nxt;
  logic [IW-1:0]   res_idx_r, res_idx_nxt;
  logic            res_st_r, res_st_nxt;

  logic            out_valid_r;
  logic [4:0]      out_gr_r;
  logic            out_st_r;
  logic [5:0]      out_cnt_r;

  logic            in_fire;
  logic [IW+4:0]   chan_ext;
  logic [IW-1:0]   chan_idx;
  logic            chan_ok;
  logic [IW+4:0]   res_ext;
  logic [CNTW+5:0] cnt_ext;
  logic            out_load;

  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  logic [TW-1:0]   ram_wdata, ram_rdata;
  logic [TW-1:0]   timer_cur;
  vaws_pkg::alu_res_t alu;

  vaws_ram #(
    .Width(TW),
    .Depth(CHANNELS)
  ) u_timer_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // never-written and stolen entries read as zero
  assign timer_cur = tval_r[ph_idx_r] ? ram_rdata : '0;

  vaws_alu u_alu (
    .timer(timer_cur),
    .best (best_val_r),
    .res  (alu)
  );

  assign in_ready  = (state_r == vaws_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_kind_c = vaws_pkg::kind_t'(in_kind);
  assign chan_ext  = {IW'(0), in_chan};
  assign chan_idx  = chan_ext[IW-1:0];
  assign chan_ok   = (chan_ext < (IW+5)'(CHANNELS));
  assign res_ext   = {5'd0, res_idx_r};
  assign cnt_ext   = {6'd0, cnt_r};
  assign out_load  = (state_r == vaws_pkg::S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    scan_idx_nxt = scan_idx_r;
    iss_nxt      = iss_r;
    ph_vld_nxt   = 1'b0;
    ph_idx_nxt   = ph_idx_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    cnt_nxt      = cnt_r;
    busy_nxt     = busy_r;
    tval_nxt     = tval_r;
    res_idx_nxt  = res_idx_r;
    res_st_nxt   = res_st_r;
    ram_we       = 1'b0;
    ram_waddr    = chan_idx;
    ram_wdata    = in_duration;
    ram_re       = 1'b0;
    ram_raddr    = scan_idx_r;

    unique case (state_r)
      vaws_pkg::S_IDLE: begin
        if (in_fire) begin
          kind_nxt     = in_kind_c;
          res_idx_nxt  = '0;
          res_st_nxt   = 1'b0;
          scan_idx_nxt = '0;
          iss_nxt      = 1'b1;
          best_val_nxt = {1'b1, TW'(0)};
          best_idx_nxt = '0;
          unique case (in_kind_c)
            vaws_pkg::KIND_TICK, vaws_pkg::KIND_ALLOC: begin
              state_nxt = vaws_pkg::S_SCAN;
            end
            vaws_pkg::KIND_START: begin
              state_nxt = vaws_pkg::S_DONE;
              if (chan_ok) begin
                ram_we             = 1'b1;
                tval_nxt[chan_idx] = 1'b1;
                busy_nxt[chan_idx] = in_track_valid;
                if (cnt_r != MaxCnt) begin
                  cnt_nxt = cnt_r + CNTW'(1);
                end
              end
            end
            default: begin
              state_nxt = vaws_pkg::S_DONE;
            end
          endcase
        end
      end

      vaws_pkg::S_SCAN: begin
        // issue stage: one read per cycle
        if (iss_r) begin
          ram_re     = 1'b1;
          ph_vld_nxt = 1'b1;
          ph_idx_nxt = scan_idx_r;
          if (scan_idx_r == LastIdx) begin
            iss_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + IW'(1);
          end
        end
        // process stage: data of the entry read last cycle
        if (ph_vld_r) begin
          if (kind_r == vaws_pkg::KIND_TICK) begin
            if (!alu.zero) begin
              ram_we    = 1'b1;
              ram_waddr = ph_idx_r;
              ram_wdata = alu.dec;
            end else begin
              if (busy_r[ph_idx_r] && (cnt_r != '0)) begin
                cnt_nxt = cnt_r - CNTW'(1);
              end
              busy_nxt[ph_idx_r] = 1'b0;
            end
            if (ph_idx_r == LastIdx) begin
              state_nxt  = vaws_pkg::S_DONE;
              ph_vld_nxt = 1'b0;
            end
          end else begin
            if (alu.lt) begin
              best_val_nxt = {1'b0, timer_cur};
              best_idx_nxt = ph_idx_r;
            end
            if (!busy_r[ph_idx_r]) begin
              res_idx_nxt = ph_idx_r;
              state_nxt   = vaws_pkg::S_DONE;
              ph_vld_nxt  = 1'b0;
              iss_nxt     = 1'b0;
            end else if (ph_idx_r == LastIdx) begin
              state_nxt  = vaws_pkg::S_STEAL;
              ph_vld_nxt = 1'b0;
            end
          end
        end
      end

      vaws_pkg::S_STEAL: begin
        tval_nxt[best_idx_r] = 1'b0;
        busy_nxt[best_idx_r] = 1'b0;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CNTW'(1);
        end
        res_idx_nxt = best_idx_r;
        res_st_nxt  = 1'b1;
        state_nxt   = vaws_pkg::S_DONE;
      end

      vaws_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = vaws_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = vaws_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vaws_pkg::S_IDLE;
      iss_r       <= 1'b0;
      ph_vld_r    <= 1'b0;
      cnt_r       <= '0;
      busy_r      <= '0;
      tval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      iss_r    <= iss_nxt;
      ph_vld_r <= ph_vld_nxt;
      cnt_r    <= cnt_nxt;
      busy_r   <= busy_nxt;
      tval_r   <= tval_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    scan_idx_r <= scan_idx_nxt;
    ph_idx_r   <= ph_idx_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_st_r   <= res_st_nxt;
    if (out_load) begin
      out_gr_r  <= res_ext[4:0];
      out_st_r  <= res_st_r;
      out_cnt_r <= cnt_ext[5:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_chan  = out_gr_r;
  assign out_stolen        = out_st_r;
  assign out_voices_in_use = out_cnt_r;

  `VAWS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= MaxCnt, "voice count above channel count")
  `VAWS_ASSERT_NOW(a_ph_in_scan, ph_vld_r, state_r == vaws_pkg::S_SCAN,
                   "entry data pending outside a scan")
  `VAWS_ASSERT_NEXT(a_steal_count, (state_r == vaws_pkg::S_STEAL) && (cnt_r != '0),
                    cnt_r == $past(cnt_r) - CNTW'(1), "steal did not release a voice")
  `VAWS_ASSERT_NEXT(a_short_item,
                    in_fire && ((in_kind_c == vaws_pkg::KIND_START) ||
                                (in_kind_c == vaws_pkg::KIND_NOP)),
                    state_r == vaws_pkg::S_DONE, "single-cycle item did not finish")

endmodule

`default_nettype wire
